[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and constants for the binary min-heap priority queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 9;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

endpackage

[rtl/bmhq_ram.sv]
// ----------------------------------------------------------------------------
// bmhq_ram
// heap key store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [bmhq_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]                   raddr,
  output logic signed [bmhq_pkg::KEY_W-1:0] rdata
);
  import bmhq_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/binary_min_heap_queue_core.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// min-heap priority queue of signed 32-bit keys in a single-port-pair ram
// ----------------------------------------------------------------------------
// in_* channel: one beat per operation, in_kind 0 pushes in_key_value,
// in_kind 1 pops the minimum. out_* channel: exactly one result beat per
// input beat, carrying status, popped key, count and the current minimum.
// cfg_wr_en/cfg_wr_data write capacity_limit; write it only while idle.
// One operation is in flight at a time; in_stall is high while it works.
// A refused operation, a push into an empty heap or a pop that leaves it
// empty goes straight to the result; any other push rises one level per
// compare against its parent; a pop sinks level by level (read first child,
// read second child, compare), with no second read on a level with a single
// child, until it stops against its children or reaches a leaf. The single
// ram read port with registered read data sets the pace of each step.
// Reset (rst_n low, synchronous) empties the heap and sets the limit to 256;
// the ram contents are not cleared. If the receiver stalls, the finished
// result waits in the output register and a new beat is still taken, but
// its result is held back until the output register frees up.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bmhq_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic signed [bmhq_pkg::KEY_W-1:0] in_key_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmhq_pkg::STATUS_W-1:0]     out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_popped_value,
  output logic [bmhq_pkg::CNT_W-1:0]        out_entry_total,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_top_value,
  output logic                              out_top_valid
);
  import bmhq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEPTH_CLAMP = (DEPTH > 511) ? 511 : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_CLAMP);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_CMP, S_UP_FIN, S_DN_LAST, S_DN_STEP, S_DN_C1, S_DN_C2, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        cap_r;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] v_r, v_nxt;
  logic signed [KEY_W-1:0] ch_r, ch_nxt;
  logic signed [KEY_W-1:0] top_r;
  status_t                 status_r, status_nxt;
  logic signed [KEY_W-1:0] popped_r, popped_nxt;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [KEY_W-1:0] out_popped_r;
  logic [CNT_W-1:0]        out_total_r;
  logic signed [KEY_W-1:0] out_top_r;
  logic                    out_top_valid_r;

  logic                    mem_we;
  logic [CNT_W-1:0]        wpos;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [KEY_W-1:0] mem_rdata;

  logic                    in_acc;
  logic                    out_free;
  logic [CNT_W-1:0]        par;
  logic [CNT_W-1:0]        in_par;
  logic [CNT_W:0]          c1;
  logic [CNT_W:0]          c2;
  logic [CNT_W:0]          cand_idx;
  logic signed [KEY_W-1:0] cand_val;
  logic                    do_cmp;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign par    = CNT_W'((pos_r - CNT_W'(1)) >> 1);
  assign in_par = CNT_W'((cnt_r - CNT_W'(1)) >> 1);
  assign c1     = {pos_r, 1'b1};
  assign c2     = c1 + (CNT_W+1)'(1);

  bmhq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(wpos)),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    v_nxt      = v_r;
    ch_nxt     = ch_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    mem_we     = 1'b0;
    wpos       = pos_r;
    mem_wdata  = v_r;
    mem_raddr  = '0;
    cand_idx   = c1;
    cand_val   = mem_rdata;
    do_cmp     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          popped_nxt = '0;
          if (in_kind == KIND_PUSH) begin
            if (cnt_r >= cap_r || cnt_r >= DEPTH_LIM) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
              pos_nxt = cnt_r;
              v_nxt   = in_key_value;
              if (cnt_r == '0) begin
                mem_we    = 1'b1;
                wpos      = '0;
                mem_wdata = in_key_value;
                state_nxt = S_DONE;
              end else begin
                mem_raddr = AW'(in_par);
                state_nxt = S_UP_CMP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              popped_nxt = top_r;
              cnt_nxt    = cnt_r - CNT_W'(1);
              pos_nxt    = '0;
              if (cnt_r == CNT_W'(1)) begin
                state_nxt = S_DONE;
              end else begin
                mem_raddr = AW'(cnt_r - CNT_W'(1));
                state_nxt = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_CMP: begin
        if (v_r < mem_rdata) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_nxt   = par;
          if (par == '0) begin
            state_nxt = S_UP_FIN;
          end else begin
            mem_raddr = AW'(CNT_W'((par - CNT_W'(1)) >> 1));
          end
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_UP_FIN: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DN_LAST: begin
        v_nxt     = mem_rdata;
        state_nxt = S_DN_STEP;
      end
      S_DN_STEP: begin
        if (c1 >= {1'b0, cnt_r}) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = AW'(c1);
          state_nxt = S_DN_C1;
        end
      end
      S_DN_C1: begin
        if (c2 < {1'b0, cnt_r}) begin
          ch_nxt    = mem_rdata;
          mem_raddr = AW'(c2);
          state_nxt = S_DN_C2;
        end else begin
          do_cmp = 1'b1;
        end
      end
      S_DN_C2: begin
        do_cmp = 1'b1;
        if (ch_r < mem_rdata) begin
          cand_val = ch_r;
        end else begin
          cand_idx = c2;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_cmp) begin
      mem_we = 1'b1;
      if (v_r < cand_val) begin
        state_nxt = S_DONE;
      end else begin
        mem_wdata = cand_val;
        pos_nxt   = CNT_W'(cand_idx);
        state_nxt = S_DN_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    pos_r    <= pos_nxt;
    v_r      <= v_nxt;
    ch_r     <= ch_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    if (mem_we && wpos == '0) begin
      top_r <= mem_wdata;
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r    <= status_r;
      out_popped_r    <= popped_r;
      out_total_r     <= cnt_r;
      out_top_r       <= (cnt_r != '0) ? top_r : '0;
      out_top_valid_r <= (cnt_r != '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_entry_total  = out_total_r;
  assign out_top_value    = out_top_r;
  assign out_top_valid    = out_top_valid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_LIM)
    else $error("entry count above store size");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> wpos < cnt_nxt)
    else $error("store write outside the live heap");

  a_top_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_entry_total != '0)))
    else $error("top_valid disagrees with entry total");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc)
    else $error("second beat taken while an operation is in flight");

endmodule
